// ===== hw/rtl/weight_per_length_moving_average_defines.svh =====
// Assertion macros for the weight per length moving average block.
// Included by the top level, which checks its own logic; no dependencies.
`ifndef WEIGHT_PER_LENGTH_MOVING_AVERAGE_DEFINES_SVH
`define WEIGHT_PER_LENGTH_MOVING_AVERAGE_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked while out of reset.
`define WPMA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define WPMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WPMA_ASSERT(lbl, clk, rstn, prop, msg)
`define WPMA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/wpma_pkg.sv =====
// Shared constants, types and helpers of the weight per length moving average.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wpma_pkg;

  localparam int unsigned MaxSamplesDef = 16;

  // Register indexes
  localparam logic [2:0] RegRateMethod = 3'd0;
  localparam logic [2:0] RegAvgWindow  = 3'd1;
  localparam logic [2:0] RegMinLength  = 3'd2;
  localparam logic [2:0] RegWidthMm    = 3'd3;
  localparam logic [2:0] RegAreaMode   = 3'd4;
  localparam logic [2:0] RegImpFactor  = 3'd5;
  localparam logic [2:0] RegDispFactor = 3'd6;
  localparam logic [2:0] RegAreaFactor = 3'd7;

  // Register reset values
  localparam logic [4:0]  AvgWindowRst  = 5'd4;
  localparam logic [31:0] MinLengthRst  = 32'd6554;
  localparam logic [15:0] WidthMmRst    = 16'd1000;
  localparam logic [31:0] ImpFactorRst  = 32'd11258999;
  localparam logic [31:0] DispFactorRst = 32'd16777216;
  localparam logic [31:0] AreaFactorRst = 32'd16777216;

  // Ring memory write control
  typedef struct packed {
    logic wr_en;
    logic clr;
  } ring_ctl_t;

  // Saturate a 64 bit quotient to 32 bits
  function automatic logic [31:0] sat_q(input logic [63:0] q);
    sat_q = (q[63:32] != 32'd0) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // Q16.16 times Q8.24 product back to Q16.16, round half up, saturating
  function automatic logic [31:0] rnd_factor(input logic [63:0] p);
    logic [40:0] t;
    t = {1'b0, p[63:24]} + {40'd0, p[23]};
    rnd_factor = (t[40:32] != 9'd0) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  // Display value in hundredths, rounded
  function automatic logic [31:0] disp_round(input logic [63:0] p);
    logic [30:0] hi;
    logic [46:0] lo;
    logic [32:0] s;
    hi = 31'(p[63:40]) * 31'd100;
    lo = {7'd0, p[39:0]} * 47'd100 + 47'h80_0000_0000;
    s  = {2'b0, hi} + {26'd0, lo[46:40]};
    disp_round = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/wpma_div.sv =====
// Restoring divider, one quotient bit per cycle, 64 bit dividend, 40 bit divisor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wpma_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [39:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [63:0]      quo_o
);

  logic [39:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [39:0] den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [40:0] trial;

  // One shift-subtract step
  always_comb begin
    trial = {rem_q, quo_q[63]};
    if (trial >= {1'b0, den_q}) begin
      rem_d = 40'(trial - {1'b0, den_q});
      quo_d = {quo_q[62:0], 1'b1};
    end else begin
      rem_d = trial[39:0];
      quo_d = {quo_q[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd63);
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) busy_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= 40'd0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ===== hw/rtl/wpma_ring.sv =====
// Sample ring memory with per-entry valid bits; an invalid entry reads as zero.
// Depends on wpma_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wpma_ring #(
  parameter int unsigned MAX_SAMPLES = wpma_pkg::MaxSamplesDef,
  localparam int unsigned AW = $clog2(MAX_SAMPLES)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wpma_pkg::ring_ctl_t ctl_i,
  input  wire logic [AW-1:0]       wr_addr_i,
  input  wire logic [31:0]         wr_data_i,
  input  wire logic [AW-1:0]       rd_addr_i,
  output logic [31:0]              rd_data_o
);

  logic [31:0]            mem [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] vld_q, vld_d;
  logic [31:0]            rd_q;
  logic                   rd_vld_q;

  // Ring clear drops all entries, a write in the same beat sets its entry
  always_comb begin
    vld_d = ctl_i.clr ? '0 : vld_q;
    if (ctl_i.wr_en) vld_d[wr_addr_i] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Synchronous write and registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) mem[wr_addr_i] <= wr_data_i;
    rd_q     <= mem[rd_addr_i];
    rd_vld_q <= vld_q[rd_addr_i];
  end

  assign rd_data_o = rd_vld_q ? rd_q : 32'd0;

endmodule
`default_nettype wire

// ===== hw/rtl/weight_per_length_moving_average.sv =====
// Weight per length moving average: top level, sequencer and multiplier.
// Depends on wpma_pkg, wpma_div, wpma_ring and the assertion macro header.
//
// Usage: one input beat per production batch on the in channel (valid/stall),
// one result beat per batch on the out channel. Configuration registers are to be
// written through cfg_we_i/cfg_idx_i/cfg_data_i only while the block is idle;
// the block itself does not enforce this. An item runs through a shared divider
// up to three times (grams per metre, ring mean, weight per area), a sequential
// read of the ring memory (one entry a cycle, n = ring fill up to MAX_SAMPLES
// entries) and the multiply states MUL0 to MUL3.
// One item is in work at a time; in_stall_o is high until the item is done.
// The result sits in an output register, so the next item is accepted while
// the receiver stalls; a finished item waits until that register is free.
// Reset clears the ring (valid bits), the running state and the registers to
// their defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "weight_per_length_moving_average_defines.svh"
module weight_per_length_moving_average #(
  parameter int unsigned MAX_SAMPLES = wpma_pkg::MaxSamplesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] batch_weight_i,
  input  wire logic [31:0] batch_length_i,
  input  wire logic [31:0] throughput_i,
  input  wire logic [31:0] line_speed_i,
  input  wire logic        suspended_i,
  input  wire logic        estimating_i,
  input  wire logic        first_batch_i,
  input  wire logic        auto_mode_i,
  input  wire logic        startup_i,
  // Output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             valid_res_o,
  output logic [31:0]      weight_per_meter_o,
  output logic [31:0]      weight_per_meter_avg_o,
  output logic [31:0]      imperial_weight_o,
  output logic [31:0]      weight_per_area_o,
  output logic [31:0]      display_value_o,
  output logic             div_fault_o
);

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned WW = (CW > 5) ? CW : 5;
  localparam int unsigned SW = 32 + CW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GDIV  = 4'd1;
  localparam logic [3:0] S_RING  = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_MDIV  = 4'd4;
  localparam logic [3:0] S_ASTRT = 4'd5;
  localparam logic [3:0] S_ADIV  = 4'd6;
  localparam logic [3:0] S_MUL0  = 4'd7;
  localparam logic [3:0] S_MUL1  = 4'd8;
  localparam logic [3:0] S_MUL2  = 4'd9;
  localparam logic [3:0] S_MUL3  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  // Configuration registers
  logic        rate_q, area_mode_q;
  logic [4:0]  avg_win_q;
  logic [31:0] min_len_q, imp_f_q, disp_f_q, area_f_q;
  logic [15:0] width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= 1'b0;
      avg_win_q   <= wpma_pkg::AvgWindowRst;
      min_len_q   <= wpma_pkg::MinLengthRst;
      width_q     <= wpma_pkg::WidthMmRst;
      area_mode_q <= 1'b0;
      imp_f_q     <= wpma_pkg::ImpFactorRst;
      disp_f_q    <= wpma_pkg::DispFactorRst;
      area_f_q    <= wpma_pkg::AreaFactorRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wpma_pkg::RegRateMethod: rate_q      <= cfg_data_i[0];
        wpma_pkg::RegAvgWindow:  avg_win_q   <= cfg_data_i[4:0];
        wpma_pkg::RegMinLength:  min_len_q   <= cfg_data_i;
        wpma_pkg::RegWidthMm:    width_q     <= cfg_data_i[15:0];
        wpma_pkg::RegAreaMode:   area_mode_q <= cfg_data_i[0];
        wpma_pkg::RegImpFactor:  imp_f_q     <= cfg_data_i;
        wpma_pkg::RegDispFactor: disp_f_q    <= cfg_data_i;
        wpma_pkg::RegAreaFactor: area_f_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control and running state
  logic [3:0]    state_q;
  logic          susp_q, est_q, first_q, auto_q, start_q, upd_q, fault_q;
  logic [AW-1:0] wp_q;
  logic [CW-1:0] fill_q, n_q, rd_idx_q;
  logic [4:0]    seen_q;
  logic          rd_vld_q, div_go_q;
  logic          out_valid_q;

  // Payload
  logic [31:0] gpm_q, avg_q, imp_q, area_q, disp_q;
  logic [SW-1:0] sum_q;
  logic [63:0] div_num_q, p_q;
  logic [39:0] div_den_q;

  // Divider
  logic        div_busy, div_done;
  logic [63:0] div_quo;

  wpma_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Ring update arithmetic
  logic          clr;
  logic [CW-1:0] w_len, fill_eff, fill_nxt, pos_inc;
  logic [AW-1:0] wp_eff, wp_nxt;
  wpma_pkg::ring_ctl_t ring_ctl;
  logic [31:0]   rd_data;
  logic          rd_en;

  always_comb begin
    if (avg_win_q == 5'd0) w_len = CW'(1);
    else if (WW'(avg_win_q) > WW'(MAX_SAMPLES)) w_len = CW'(MAX_SAMPLES);
    else w_len = CW'(avg_win_q);
    clr      = (auto_q && start_q) || (avg_win_q != seen_q);
    wp_eff   = clr ? '0 : wp_q;
    fill_eff = clr ? '0 : fill_q;
    pos_inc  = CW'(wp_eff) + CW'(1);
    wp_nxt   = (pos_inc >= w_len) ? '0 : AW'(pos_inc);
    fill_nxt = (fill_eff < w_len) ? fill_eff + CW'(1) : fill_eff;
    ring_ctl.clr   = (state_q == S_RING) && clr;
    ring_ctl.wr_en = (state_q == S_RING) && !est_q && !first_q;
    rd_en = (state_q == S_SUM) && (rd_idx_q < n_q);
  end

  wpma_ring #(.MAX_SAMPLES(MAX_SAMPLES)) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ring_ctl),
    .wr_addr_i (wp_eff),
    .wr_data_i (gpm_q),
    .rd_addr_i (rd_idx_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // Multiplier operands
  logic [31:0] mul_a, mul_b;
  always_comb begin
    unique case (state_q)
      S_MUL0:  begin mul_a = upd_q ? avg_q : gpm_q; mul_b = imp_f_q; end
      S_MUL1:  begin mul_a = avg_q; mul_b = disp_f_q; end
      default: begin mul_a = area_q; mul_b = area_f_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= {32'd0, mul_a} * {32'd0, mul_b};
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q                <= S_IDLE;
      wp_q                   <= '0;
      fill_q                 <= '0;
      seen_q                 <= 5'd0;
      gpm_q                  <= 32'd0;
      avg_q                  <= 32'd0;
      rd_vld_q               <= 1'b0;
      div_go_q               <= 1'b0;
      out_valid_q            <= 1'b0;
      susp_q                 <= 1'b0;
      est_q                  <= 1'b0;
      first_q                <= 1'b0;
      auto_q                 <= 1'b0;
      start_q                <= 1'b0;
      upd_q                  <= 1'b0;
      fault_q                <= 1'b0;
      n_q                    <= '0;
      rd_idx_q               <= '0;
      sum_q                  <= '0;
      div_num_q              <= 64'd0;
      div_den_q              <= 40'd0;
      imp_q                  <= 32'd0;
      area_q                 <= 32'd0;
      disp_q                 <= 32'd0;
      valid_res_o            <= 1'b0;
      weight_per_meter_o     <= 32'd0;
      weight_per_meter_avg_o <= 32'd0;
      imperial_weight_o      <= 32'd0;
      weight_per_area_o      <= 32'd0;
      display_value_o        <= 32'd0;
      div_fault_o            <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      // Output register: load a finished item, drop a taken beat
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            susp_q  <= suspended_i;
            est_q   <= estimating_i;
            first_q <= first_batch_i;
            auto_q  <= auto_mode_i;
            start_q <= startup_i;
            upd_q   <= 1'b0;
            fault_q <= 1'b0;
            if (suspended_i) begin
              state_q <= S_DONE;
            end else if (rate_q) begin
              if (line_speed_i == 32'd0) begin
                fault_q <= 1'b1;
                state_q <= S_RING;
              end else begin
                div_num_q <= {6'd0, 42'(throughput_i) * 42'd1000, 16'd0};
                div_den_q <= 40'(line_speed_i) * 40'd60;
                div_go_q  <= 1'b1;
                state_q   <= S_GDIV;
              end
            end else if (batch_length_i > min_len_q) begin
              div_num_q <= {6'd0, 42'(batch_weight_i) * 42'd1000, 16'd0};
              div_den_q <= {8'd0, batch_length_i};
              div_go_q  <= 1'b1;
              state_q   <= S_GDIV;
            end else begin
              state_q <= S_RING;
            end
          end
        end
        S_GDIV: begin
          div_go_q <= 1'b0;
          if (div_done) begin
            gpm_q   <= wpma_pkg::sat_q(div_quo);
            state_q <= S_RING;
          end
        end
        S_RING: begin
          seen_q <= avg_win_q;
          if (!est_q && !first_q) begin
            wp_q     <= wp_nxt;
            fill_q   <= fill_nxt;
            n_q      <= fill_nxt;
            rd_idx_q <= '0;
            sum_q    <= '0;
            upd_q    <= 1'b1;
            state_q  <= S_SUM;
          end else begin
            wp_q    <= wp_eff;
            fill_q  <= fill_eff;
            state_q <= S_ASTRT;
          end
        end
        S_SUM: begin
          if (rd_en) rd_idx_q <= rd_idx_q + CW'(1);
          if (rd_vld_q) sum_q <= sum_q + SW'(rd_data);
          if (!rd_en && !rd_vld_q) begin
            div_num_q <= 64'(sum_q);
            div_den_q <= 40'(n_q);
            div_go_q  <= 1'b1;
            state_q   <= S_MDIV;
          end
        end
        S_MDIV: begin
          div_go_q <= 1'b0;
          if (div_done) begin
            avg_q   <= div_quo[31:0];
            state_q <= S_ASTRT;
          end
        end
        S_ASTRT: begin
          if (width_q == 16'd0) begin
            area_q  <= 32'd0;
            state_q <= S_MUL0;
          end else begin
            div_num_q <= 64'(42'(avg_q) * 42'd1000);
            div_den_q <= 40'(width_q);
            div_go_q  <= 1'b1;
            state_q   <= S_ADIV;
          end
        end
        S_ADIV: begin
          div_go_q <= 1'b0;
          if (div_done) begin
            area_q  <= wpma_pkg::sat_q(div_quo);
            state_q <= S_MUL0;
          end
        end
        S_MUL0: state_q <= S_MUL1;
        S_MUL1: begin
          imp_q   <= wpma_pkg::rnd_factor(p_q);
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          disp_q  <= wpma_pkg::disp_round(p_q);
          state_q <= S_MUL3;
        end
        S_MUL3: begin
          if (area_mode_q) area_q <= wpma_pkg::rnd_factor(p_q);
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Hand over once the output register is free
          if (!out_valid_q || !out_stall_i) begin
            valid_res_o            <= !susp_q;
            weight_per_meter_o     <= susp_q ? 32'd0 : gpm_q;
            weight_per_meter_avg_o <= susp_q ? 32'd0 : avg_q;
            imperial_weight_o      <= susp_q ? 32'd0 : imp_q;
            weight_per_area_o      <= susp_q ? 32'd0 : area_q;
            display_value_o        <= susp_q ? 32'd0 : disp_q;
            div_fault_o            <= susp_q ? 1'b0 : fault_q;
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Checks
  `WPMA_ASSERT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o |=> state_q != S_IDLE, "accepted beat did not start work")
  `WPMA_ASSERT(a_div_free, clk_i, rst_ni, div_go_q |-> !div_busy, "divider launched while busy")
  `WPMA_ASSERT_ALWAYS(a_fill_bound, clk_i, fill_q <= CW'(MAX_SAMPLES), "fill count beyond ring depth")

endmodule
`default_nettype wire

// ===== sim/tb_weight_per_length_moving_average.sv =====
// Testbench for weight_per_length_moving_average: queued batch driver, result monitor
// and a per-batch predictor of grams per metre, ring mean and derived units.
// Depends on wpma_pkg and the block RTL.
`timescale 1ns / 1ps
module tb_weight_per_length_moving_average;

  localparam int unsigned Depth = 16;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned DrainCycles = 300;

  typedef struct packed {
    logic [31:0] weight;
    logic [31:0] length;
    logic [31:0] tput;
    logic [31:0] speed;
    logic        susp;
    logic        est;
    logic        first;
    logic        autom;
    logic        start;
  } batch_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] gpm;
    logic [31:0] avg;
    logic [31:0] imp;
    logic [31:0] area;
    logic [31:0] disp;
    logic        fault;
  } gauge_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  batch_t cur = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  gauge_t got;

  weight_per_length_moving_average i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .batch_weight_i(cur.weight), .batch_length_i(cur.length),
    .throughput_i(cur.tput), .line_speed_i(cur.speed),
    .suspended_i(cur.susp), .estimating_i(cur.est), .first_batch_i(cur.first),
    .auto_mode_i(cur.autom), .startup_i(cur.start),
    .out_valid_o, .out_stall_i,
    .valid_res_o(got.vld), .weight_per_meter_o(got.gpm),
    .weight_per_meter_avg_o(got.avg), .imperial_weight_o(got.imp),
    .weight_per_area_o(got.area), .display_value_o(got.disp),
    .div_fault_o(got.fault)
  );

  always #5 clk_i = ~clk_i;

  // Predictor copy of registers and state
  logic        m_rate, m_amode;
  logic [4:0]  m_win, m_seen;
  logic [31:0] m_minlen, m_imp_f, m_disp_f, m_area_f, m_gpm, m_avg;
  logic [15:0] m_width;
  logic [31:0] m_ring [Depth];
  int unsigned m_wpos, m_fill;

  batch_t batch_q[$];
  gauge_t expected_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit hold_sender = 1'b0;
  bit in_taken = 1'b0;

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] seen);
    $display("mismatch %s: expected %h got %h at %0t", what, want, seen, $realtime);
    errors++;
  endtask

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] scale_q24(input logic [31:0] x, input logic [31:0] f);
    logic [63:0] p;
    p = 64'(x) * 64'(f);
    return sat32((p >> 24) + 64'(p[23]));
  endfunction

  task automatic clear_ring();
    for (int i = 0; i < Depth; i++) m_ring[i] = '0;
    m_wpos = 0;
    m_fill = 0;
  endtask

  task automatic model_reset();
    m_rate = 1'b0; m_win = wpma_pkg::AvgWindowRst; m_minlen = wpma_pkg::MinLengthRst;
    m_width = wpma_pkg::WidthMmRst;
    m_amode = 1'b0; m_imp_f = wpma_pkg::ImpFactorRst; m_disp_f = wpma_pkg::DispFactorRst;
    m_area_f = wpma_pkg::AreaFactorRst;
    clear_ring();
    m_gpm = '0; m_avg = '0; m_seen = '0;
  endtask

  // Expected result of one batch; updates the predictor state
  task automatic predict_gauge(input batch_t b, output gauge_t r);
    logic [127:0] num, den;
    logic [63:0] p, sum, d;
    int unsigned w, n;
    bit upd;
    r = '0;
    upd = 1'b0;
    if (b.susp) return;
    if (m_rate) begin
      if (b.speed == 0) r.fault = 1'b1;
      else begin
        num = (128'(b.tput) * 1000) << 16;
        den = 128'(b.speed) * 60;
        m_gpm = sat32(64'(num / den));
      end
    end else if (b.length > m_minlen) begin
      num = (128'(b.weight) * 1000) << 16;
      m_gpm = sat32(64'(num / 128'(b.length)));
    end
    if (b.autom && b.start) clear_ring();
    if (m_win != m_seen) begin
      m_seen = m_win;
      clear_ring();
    end
    if (!b.est && !b.first) begin
      w = (m_win < 1) ? 1 : ((m_win > Depth) ? Depth : m_win);
      m_ring[m_wpos] = m_gpm;
      m_wpos = (m_wpos + 1 >= w) ? 0 : m_wpos + 1;
      if (m_fill < w) m_fill++;
      n = m_fill;
      sum = '0;
      for (int i = 0; i < n; i++) sum += 64'(m_ring[i]);
      m_avg = 32'(sum / n);
      upd = 1'b1;
    end
    r.vld = 1'b1;
    r.gpm = m_gpm;
    r.avg = m_avg;
    r.imp = scale_q24(upd ? m_avg : m_gpm, m_imp_f);
    if (m_width != 0) begin
      r.area = sat32((64'(m_avg) * 1000) / 64'(m_width));
      if (m_amode) r.area = scale_q24(r.area, m_area_f);
    end
    p = 64'(m_avg) * 64'(m_disp_f);
    d = (p >> 40) * 100 + ((64'(p[39:0]) * 100 + (64'd1 << 39)) >> 40);
    r.disp = sat32(d);
  endtask

  // Driver: bursts and gaps, inputs change on the falling edge
  int unsigned burst_left = 0, gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (in_valid_i) begin
        // previous beat was taken at the last rising edge
        batch_t nb;
        nb = '0;
        if (!hold_sender && gap_left == 0 && burst_left > 0 && batch_q.size() > 0) begin
          nb = batch_q.pop_front();
          cur <= nb;
          burst_left--;
        end else begin
          in_valid_i <= 1'b0;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (!hold_sender && batch_q.size() > 0) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        cur <= batch_q.pop_front();
        in_valid_i <= 1'b1;
        burst_left--;
      end
    end
  end

  // Receiver stall pattern: long quiet runs and stall bursts
  int unsigned stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase = (stall_phase + 1) % 200;
    if (stall_phase < 60) out_stall_i <= 1'b0;
    else if (stall_phase < 120) out_stall_i <= ($urandom_range(0, 3) == 0);
    else out_stall_i <= ($urandom_range(0, 1) == 0);
  end

  // Monitor: predicts at input acceptance, checks at output acceptance
  always @(posedge clk_i) begin
    gauge_t e;
    cycles <= cycles + 1;
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      predict_gauge(cur, e);
      expected_q.push_back(e);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report("unexpected beat", '0, '0);
      end else begin
        e = expected_q.pop_front();
        if (got.vld !== e.vld) report("valid_res", 32'(e.vld), 32'(got.vld));
        if (got.gpm !== e.gpm) report("weight_per_meter", e.gpm, got.gpm);
        if (got.avg !== e.avg) report("weight_per_meter_avg", e.avg, got.avg);
        if (got.imp !== e.imp) report("imperial_weight", e.imp, got.imp);
        if (got.area !== e.area) report("weight_per_area", e.area, got.area);
        if (got.disp !== e.disp) report("display_value", e.disp, got.disp);
        if (got.fault !== e.fault) report("div_fault", 32'(e.fault), 32'(got.fault));
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return '0;
      2: return $urandom_range(1, 65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic batch_t rand_batch(input bit regular);
    batch_t b;
    b.weight = $urandom_range(0, 3) == 0 ? rand_word() : $urandom_range(1 << 16, 400 << 16);
    b.length = $urandom_range(0, 3) == 0 ? rand_word() : $urandom_range(1 << 12, 200 << 16);
    b.tput = $urandom_range(0, 3) == 0 ? rand_word() : $urandom_range(1 << 16, 900 << 16);
    b.speed = $urandom_range(0, 7) == 0 ? rand_word() : $urandom_range(1 << 14, 300 << 16);
    b.susp = regular ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 1) == 1);
    b.est = regular ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 1) == 1);
    b.first = regular ? ($urandom_range(0, 11) == 0) : ($urandom_range(0, 1) == 1);
    b.autom = ($urandom_range(0, 1) == 1);
    b.start = regular ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 1) == 1);
    return b;
  endfunction

  // Wait until every batch is sent and every result is in, then let the block drain
  task automatic wait_idle();
    while (batch_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      wpma_pkg::RegRateMethod: m_rate = val[0];
      wpma_pkg::RegAvgWindow:  m_win = val[4:0];
      wpma_pkg::RegMinLength:  m_minlen = val;
      wpma_pkg::RegWidthMm:    m_width = val[15:0];
      wpma_pkg::RegAreaMode:   m_amode = val[0];
      wpma_pkg::RegImpFactor:  m_imp_f = val;
      wpma_pkg::RegDispFactor: m_disp_f = val;
      default:                 m_area_f = val;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_config();
    write_reg(wpma_pkg::RegRateMethod, $urandom_range(0, 1));
    write_reg(wpma_pkg::RegAvgWindow, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                                  : $urandom_range(1, 16));
    write_reg(wpma_pkg::RegMinLength,
              ($urandom_range(0, 5) == 0) ? rand_word() : $urandom_range(0, 1 << 16));
    write_reg(wpma_pkg::RegWidthMm, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 65535));
    write_reg(wpma_pkg::RegAreaMode, $urandom_range(0, 1));
    write_reg(wpma_pkg::RegImpFactor, rand_word());
    write_reg(wpma_pkg::RegDispFactor,
              ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(0, 1 << 26));
    write_reg(wpma_pkg::RegAreaFactor, rand_word());
  endtask

  initial begin
    batch_t b;
    model_reset();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: weight method with defaults, extremes, short batch, flags
    b = '0; b.weight = 32'd5 << 16; b.length = 32'd2 << 16; batch_q.push_back(b);
    b.weight = 32'hFFFF_FFFF; b.length = 32'd1 << 16; batch_q.push_back(b);
    b.length = 32'hFFFF_FFFF; batch_q.push_back(b);
    b.weight = 32'd7 << 16; b.length = 32'd6554; batch_q.push_back(b);
    b.length = 32'd6555; batch_q.push_back(b);
    b.length = 32'd3 << 16; b.susp = 1'b1; batch_q.push_back(b);
    b.susp = 1'b0; b.est = 1'b1; batch_q.push_back(b);
    b.est = 1'b0; b.first = 1'b1; batch_q.push_back(b);
    b.first = 1'b0; b.autom = 1'b1; b.start = 1'b1; batch_q.push_back(b);
    b.autom = 1'b0; batch_q.push_back(b);
    b.autom = 1'b1; b.start = 1'b0; batch_q.push_back(b);
    b.weight = '0; batch_q.push_back(b);
    wait_idle();

    // Directed: rate method, zero speed, window 0 and above max, zero width
    write_reg(wpma_pkg::RegRateMethod, 32'd1);
    write_reg(wpma_pkg::RegAvgWindow, 32'd0);
    write_reg(wpma_pkg::RegWidthMm, 32'd0);
    write_reg(wpma_pkg::RegAreaMode, 32'd1);
    write_reg(wpma_pkg::RegImpFactor, 32'hFFFF_FFFF);
    write_reg(wpma_pkg::RegDispFactor, 32'hFFFF_FFFF);
    write_reg(wpma_pkg::RegAreaFactor, 32'hFFFF_FFFF);
    write_reg(wpma_pkg::RegMinLength, 32'hFFFF_FFFF);
    b = '0; b.tput = 32'd100 << 16; b.speed = 32'd10 << 16; batch_q.push_back(b);
    b.speed = '0; batch_q.push_back(b);
    b.tput = 32'hFFFF_FFFF; b.speed = 32'd1; batch_q.push_back(b);
    b.speed = 32'hFFFF_FFFF; batch_q.push_back(b);
    wait_idle();
    write_reg(wpma_pkg::RegAvgWindow, 32'd31);
    write_reg(wpma_pkg::RegWidthMm, 32'h0000_FFFF);
    for (int i = 0; i < 20; i++) batch_q.push_back(rand_batch(1'b1));
    wait_idle();
    write_reg(wpma_pkg::RegWidthMm, 32'd1);
    write_reg(wpma_pkg::RegAvgWindow, 32'd16);
    write_reg(wpma_pkg::RegMinLength, 32'd0);
    write_reg(wpma_pkg::RegRateMethod, 32'd0);
    write_reg(wpma_pkg::RegAreaMode, 32'd0);
    write_reg(wpma_pkg::RegImpFactor, 32'd0);
    write_reg(wpma_pkg::RegDispFactor, 32'd0);
    write_reg(wpma_pkg::RegAreaFactor, 32'd0);

    // Random phases with a fresh setting each time
    for (int ph = 0; ph < 13; ph++) begin
      for (int i = 0; i < 100; i++) batch_q.push_back(rand_batch($urandom_range(0, 9) != 0));
      if (ph == 4) begin
        // sender holds off until every result is in
        while (batch_q.size() > 50) @(posedge clk_i);
        hold_sender = 1'b1;
        while (in_valid_i || expected_q.size() > 0) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      wait_idle();
      if (ph != 12) random_config();
    end
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
